// ----- sv/dtse_pkg.sv -----
`timescale 1ns / 1ps

package dtse_pkg;

  localparam logic [2:0] FIELD_HOUR   = 3'd0;
  localparam logic [2:0] FIELD_MINUTE = 3'd1;
  localparam logic [2:0] FIELD_DAY    = 3'd2;
  localparam logic [2:0] FIELD_MONTH  = 3'd3;
  localparam logic [2:0] FIELD_YEAR   = 3'd4;

  localparam logic [13:0] YEAR_MIN   = 14'd2000;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [13:0] YEAR_RESET = 14'd2026;

  localparam logic [6:0] HOURS_PER_DAY = 7'd24;
  localparam logic [6:0] MIN_PER_HOUR  = 7'd60;
  localparam logic [6:0] MONTHS        = 7'd12;
  localparam logic [6:0] CENTURY       = 7'd100;

  localparam logic [4:0] LAST_HOUR   = 5'd23;
  localparam logic [5:0] LAST_MINUTE = 6'd59;
  localparam logic [3:0] LAST_MONTH  = 4'd12;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic prep;
    logic post;
    logic clamp;
    logic val;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_needed;
    logic div_done;
    logic clamp_needed;
  } sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                         len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
      default:                      len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- sv/date_time_setting_editor.sv -----
`timescale 1ns / 1ps

// Sequence: an accepted item goes through prep and validate before out_valid rises; a load,
// or an hour/minute/day/month/year change with counts, first runs the reciprocal-multiply
// remainder unit (field wrap, year / 100), and a load, month or year change then clamps the day.
// Throughput: one item at a time; the next is taken the cycle after its result is taken.
// Reset (rst, synchronous): 00:00, day 1, month 1, year 2026, hour field, finished clear.
module date_time_setting_editor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [4:0]  load_hour,
  input  logic [5:0]  load_minute,
  input  logic [4:0]  load_day,
  input  logic [3:0]  load_month,
  input  logic [13:0] load_year,
  input  logic [7:0]  plus_count,
  input  logic [7:0]  minus_count,
  input  logic [7:0]  validate_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [4:0]  day,
  output logic [3:0]  month,
  output logic [13:0] year,
  output logic [2:0]  editing_field,
  output logic        finished,
  output logic        commit
);

  dtse_pkg::cmd_t cmd;
  dtse_pkg::sts_t sts;

  dtse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dtse_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .action         (action),
    .load_hour      (load_hour),
    .load_minute    (load_minute),
    .load_day       (load_day),
    .load_month     (load_month),
    .load_year      (load_year),
    .plus_count     (plus_count),
    .minus_count    (minus_count),
    .validate_count (validate_count),
    .hour           (hour),
    .minute         (minute),
    .day            (day),
    .month          (month),
    .year           (year),
    .editing_field  (editing_field),
    .finished       (finished),
    .commit         (commit)
  );

endmodule

// ----- sv/dtse_div.sv -----
`timescale 1ns / 1ps

// Remainder and quotient by reciprocal multiplication, registered through v1, v2, v3 to done.
// Divisor is one of the wrap lengths (12, 24, 60, 28..31) or 100. The quotient
// estimate is never high and at most one low; one compare and subtract fixes it.
// Requires dividend < 128 * divisor.
module dtse_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [13:0] dividend,
  input  logic [6:0]  divisor,
  output logic [13:0] rem,
  output logic [6:0]  quot,
  output logic        done
);

  logic [13:0] x_q;
  logic [6:0]  d_q;
  logic [12:0] recip;
  logic [12:0] recip_q;
  logic [26:0] prod;
  logic [6:0]  qe_q;
  logic [13:0] qd;
  logic [13:0] r_q;
  logic        fits;
  logic [6:0]  q_inc;
  logic        v1;
  logic        v2;
  logic        v3;

  // floor(2^16 / divisor)
  always_comb begin
    unique case (divisor)
      dtse_pkg::MONTHS:        recip = 13'd5461;
      dtse_pkg::HOURS_PER_DAY: recip = 13'd2730;
      7'd28:                   recip = 13'd2340;
      7'd29:                   recip = 13'd2259;
      7'd30:                   recip = 13'd2184;
      7'd31:                   recip = 13'd2114;
      dtse_pkg::MIN_PER_HOUR:  recip = 13'd1092;
      dtse_pkg::CENTURY:       recip = 13'd655;
      default:                 recip = 13'd0;
    endcase
  end

  assign prod  = x_q * recip_q;
  assign qd    = qe_q * d_q;
  assign fits  = (r_q >= {7'd0, d_q});
  assign q_inc = qe_q + 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_q     <= dividend;
      d_q     <= divisor;
      recip_q <= recip;
    end
    // quotient fits 7 bits, so the upper product bits are zero
    if (v1) begin
      qe_q <= prod[22:16];
    end
    if (v2) begin
      r_q <= x_q - qd;
    end
    if (v3) begin
      if (fits) begin
        rem  <= r_q - {7'd0, d_q};
        quot <= q_inc;
      end else begin
        rem  <= r_q;
        quot <= qe_q;
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    (v1 || v2 || v3) |-> !start)
    else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(v3))
    else $error("divider done without work");
  a_known_divisor: assert property (@(posedge clk) disable iff (rst)
    start |-> (recip != 13'd0))
    else $error("divider started with an unsupported divisor");

endmodule

// ----- sv/dtse_datapath.sv -----
`timescale 1ns / 1ps

module dtse_datapath (
  input  logic              clk,
  input  logic              rst,
  input  dtse_pkg::cmd_t    cmd,
  output dtse_pkg::sts_t    sts,
  input  logic              action,
  input  logic [4:0]        load_hour,
  input  logic [5:0]        load_minute,
  input  logic [4:0]        load_day,
  input  logic [3:0]        load_month,
  input  logic [13:0]       load_year,
  input  logic [7:0]        plus_count,
  input  logic [7:0]        minus_count,
  input  logic [7:0]        validate_count,
  output logic [4:0]        hour,
  output logic [5:0]        minute,
  output logic [4:0]        day,
  output logic [3:0]        month,
  output logic [13:0]       year,
  output logic [2:0]        editing_field,
  output logic              finished,
  output logic              commit
);

  // latched item
  logic        act_q;
  logic [4:0]  ld_hour_q;
  logic [5:0]  ld_minute_q;
  logic [4:0]  ld_day_q;
  logic [3:0]  ld_month_q;
  logic [13:0] ld_year_q;
  logic [7:0]  plus_q;
  logic [7:0]  minus_q;
  logic [7:0]  validate_q;

  // editor state
  logic [4:0]  hour_value;
  logic [5:0]  minute_value;
  logic [4:0]  day_value;
  logic [3:0]  month_value;
  logic [13:0] year_value;
  logic [2:0]  field_select;
  logic        done_flag;
  logic        leap_flag;
  logic        tgt_leap;
  logic        commit_q;

  logic [8:0]  delta;
  logic        apply;
  logic [4:0]  cur_len;
  logic [14:0] ysum;
  logic [13:0] year_upd;
  logic [13:0] year_ld;
  logic [11:0] wrap_base;
  logic [6:0]  wrap_n;
  logic [11:0] wrap_sum;
  logic        div_start;
  logic [13:0] div_dividend;
  logic [6:0]  div_divisor;
  logic [13:0] div_rem;
  logic [6:0]  div_quot;
  logic        div_done;
  logic        leap_calc;
  logic [4:0]  day_min1;

  assign delta   = {1'b0, plus_q} - {1'b0, minus_q};
  assign apply   = act_q && ((plus_q != 8'd0) || (minus_q != 8'd0))
                   && (field_select <= dtse_pkg::FIELD_YEAR);
  assign cur_len = dtse_pkg::month_len(month_value, leap_flag);

  assign ysum = {1'b0, year_value} + {{6{delta[8]}}, delta};
  always_comb begin
    if (ysum < {1'b0, dtse_pkg::YEAR_MIN}) begin
      year_upd = dtse_pkg::YEAR_MIN;
    end else if (ysum > {1'b0, dtse_pkg::YEAR_MAX}) begin
      year_upd = dtse_pkg::YEAR_MAX;
    end else begin
      year_upd = ysum[13:0];
    end
  end

  always_comb begin
    if (ld_year_q < dtse_pkg::YEAR_MIN) begin
      year_ld = dtse_pkg::YEAR_MIN;
    end else if (ld_year_q > dtse_pkg::YEAR_MAX) begin
      year_ld = dtse_pkg::YEAR_MAX;
    end else begin
      year_ld = ld_year_q;
    end
  end

  // offset of 32*n keeps the sum positive before the remainder is taken
  always_comb begin
    unique case (field_select)
      dtse_pkg::FIELD_HOUR: begin
        wrap_base = {7'd0, hour_value};
        wrap_n    = dtse_pkg::HOURS_PER_DAY;
      end
      dtse_pkg::FIELD_MINUTE: begin
        wrap_base = {6'd0, minute_value};
        wrap_n    = dtse_pkg::MIN_PER_HOUR;
      end
      dtse_pkg::FIELD_DAY: begin
        wrap_base = {7'd0, day_value - 5'd1};
        wrap_n    = {2'd0, cur_len};
      end
      dtse_pkg::FIELD_MONTH: begin
        wrap_base = {8'd0, month_value - 4'd1};
        wrap_n    = dtse_pkg::MONTHS;
      end
      default: begin
        wrap_base = '0;
        wrap_n    = dtse_pkg::CENTURY;
      end
    endcase
  end

  assign wrap_sum = wrap_base + {wrap_n, 5'b0} + {{3{delta[8]}}, delta};

  assign div_start = cmd.prep && (!act_q || apply);
  always_comb begin
    if (!act_q) begin
      div_dividend = year_ld;
      div_divisor  = dtse_pkg::CENTURY;
    end else if (field_select == dtse_pkg::FIELD_YEAR) begin
      div_dividend = year_upd;
      div_divisor  = dtse_pkg::CENTURY;
    end else begin
      div_dividend = {2'd0, wrap_sum};
      div_divisor  = wrap_n;
    end
  end

  dtse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rem      (div_rem),
    .quot     (div_quot),
    .done     (div_done)
  );

  // quotient is year / 100: divisible by 400 when its low two bits are zero
  assign leap_calc = (div_rem == 14'd0) ? (div_quot[1:0] == 2'd0)
                                        : (year_value[1:0] == 2'd0);
  assign day_min1  = (day_value == 5'd0) ? 5'd1 : day_value;

  assign sts.div_needed   = !act_q || apply;
  assign sts.div_done     = div_done;
  assign sts.clamp_needed = tgt_leap || (field_select == dtse_pkg::FIELD_MONTH);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q       <= action;
      ld_hour_q   <= load_hour;
      ld_minute_q <= load_minute;
      ld_day_q    <= load_day;
      ld_month_q  <= load_month;
      ld_year_q   <= load_year;
      plus_q      <= plus_count;
      minus_q     <= minus_count;
      validate_q  <= validate_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_value   <= '0;
      minute_value <= '0;
      day_value    <= 5'd1;
      month_value  <= 4'd1;
      year_value   <= dtse_pkg::YEAR_RESET;
      field_select <= dtse_pkg::FIELD_HOUR;
      done_flag    <= 1'b0;
      leap_flag    <= 1'b0;
      tgt_leap     <= 1'b0;
      commit_q     <= 1'b0;
    end else begin
      if (cmd.prep) begin
        commit_q <= 1'b0;
        if (!act_q) begin
          hour_value   <= (ld_hour_q > dtse_pkg::LAST_HOUR) ? dtse_pkg::LAST_HOUR : ld_hour_q;
          minute_value <= (ld_minute_q > dtse_pkg::LAST_MINUTE) ? dtse_pkg::LAST_MINUTE
                                                                : ld_minute_q;
          if (ld_month_q == 4'd0) begin
            month_value <= 4'd1;
          end else if (ld_month_q > dtse_pkg::LAST_MONTH) begin
            month_value <= dtse_pkg::LAST_MONTH;
          end else begin
            month_value <= ld_month_q;
          end
          year_value   <= year_ld;
          day_value    <= ld_day_q;
          field_select <= dtse_pkg::FIELD_HOUR;
          done_flag    <= 1'b0;
          tgt_leap     <= 1'b1;
        end else begin
          tgt_leap <= (field_select == dtse_pkg::FIELD_YEAR);
          if (apply && (field_select == dtse_pkg::FIELD_YEAR)) begin
            year_value <= year_upd;
          end
        end
      end

      if (cmd.post) begin
        if (tgt_leap) begin
          leap_flag <= leap_calc;
        end else begin
          unique case (field_select)
            dtse_pkg::FIELD_HOUR:   hour_value   <= div_rem[4:0];
            dtse_pkg::FIELD_MINUTE: minute_value <= div_rem[5:0];
            dtse_pkg::FIELD_DAY:    day_value    <= div_rem[4:0] + 5'd1;
            dtse_pkg::FIELD_MONTH:  month_value  <= div_rem[3:0] + 4'd1;
            default: ;
          endcase
        end
      end

      if (cmd.clamp) begin
        day_value <= (day_min1 > cur_len) ? cur_len : day_min1;
      end

      if (cmd.val) begin
        commit_q <= 1'b0;
        if (act_q && (validate_q != 8'd0)) begin
          if (field_select < dtse_pkg::FIELD_YEAR) begin
            field_select <= field_select + 3'd1;
          end else if (field_select == dtse_pkg::FIELD_YEAR) begin
            commit_q  <= 1'b1;
            done_flag <= 1'b1;
          end else begin
            field_select <= dtse_pkg::FIELD_HOUR;
          end
        end
      end
    end
  end

  assign hour          = hour_value;
  assign minute        = minute_value;
  assign day           = day_value;
  assign month         = month_value;
  assign year          = year_value;
  assign editing_field = field_select;
  assign finished      = done_flag;
  assign commit        = commit_q;

  a_field_range: assert property (@(posedge clk) disable iff (rst)
    field_select <= dtse_pkg::FIELD_YEAR)
    else $error("field selector out of range");
  a_commit_done: assert property (@(posedge clk) disable iff (rst)
    commit_q |-> (done_flag && field_select == dtse_pkg::FIELD_YEAR))
    else $error("commit without finished on year");
  a_year_range: assert property (@(posedge clk) disable iff (rst)
    (year_value >= dtse_pkg::YEAR_MIN) && (year_value <= dtse_pkg::YEAR_MAX))
    else $error("year out of range");
  a_post_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.post |-> $past(div_done))
    else $error("field written before divider finished");

endmodule

// ----- sv/dtse_ctrl.sv -----
`timescale 1ns / 1ps

module dtse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dtse_pkg::cmd_t    cmd,
  input  dtse_pkg::sts_t    sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_POST,
    S_CLAMP,
    S_VAL,
    S_OUT
  } state_t;

  state_t state;

  always_comb begin
    cmd.latch = in_valid && in_ready;
    cmd.prep  = (state == S_PREP);
    cmd.post  = (state == S_POST);
    cmd.clamp = (state == S_CLAMP);
    cmd.val   = (state == S_VAL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_ready <= 1'b0;
            state    <= S_PREP;
          end
        end
        S_PREP: begin
          state <= sts.div_needed ? S_DIV : S_VAL;
        end
        S_DIV: begin
          if (sts.div_done) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          state <= sts.clamp_needed ? S_CLAMP : S_VAL;
        end
        S_CLAMP: begin
          state <= S_VAL;
        end
        S_VAL: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while a result is pending");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == S_IDLE))
    else $error("ready outside idle");
  a_valid_from_val: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_VAL))
    else $error("result shown before update finished");

endmodule
